@@ src/awcg_pkg.sv @@
// ============================================================================
// awcg_pkg
// Shared types and constants for the affine warp coordinate generator.
// ============================================================================
package awcg_pkg;

    localparam int COORD_BITS_DEF = 12;   // destination coordinate width
    localparam int FRAC_BITS_DEF  = 5;    // bilinear fraction bits per axis
    localparam int AB_MIN_BITS    = 10;   // lower bound of the product scale bits
    localparam int COEF_FRAC_BITS = 16;   // Q16.16 coefficients
    localparam int COEF_W         = 32;
    localparam int OUT_W          = 16;   // saturated source coordinate width
    localparam int FIDX_W         = 10;   // fraction index width
    localparam int OUT_TDATA_W    = 48;   // src_x, src_y, frac_index, padded
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_E      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_F      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] e;
        logic signed [COEF_W-1:0] f;
        logic                     mode;
    } t_cfg;

endpackage

@@ src/awcg_cfg.sv @@
// ============================================================================
// awcg_cfg
// Configuration register file: six Q16.16 matrix coefficients and the mode.
// ============================================================================
module awcg_cfg
    import awcg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.a    <= COEF_ONE;
            r_cfg.b    <= COEF_ZERO;
            r_cfg.c    <= COEF_ZERO;
            r_cfg.d    <= COEF_ZERO;
            r_cfg.e    <= COEF_ONE;
            r_cfg.f    <= COEF_ZERO;
            r_cfg.mode <= MODE_NEAREST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_A:      r_cfg.a    <= $signed(i_cfg_data);
                REG_COEF_B:      r_cfg.b    <= $signed(i_cfg_data);
                REG_COEF_C:      r_cfg.c    <= $signed(i_cfg_data);
                REG_COEF_D:      r_cfg.d    <= $signed(i_cfg_data);
                REG_COEF_E:      r_cfg.e    <= $signed(i_cfg_data);
                REG_COEF_F:      r_cfg.f    <= $signed(i_cfg_data);
                REG_INTERP_MODE: r_cfg.mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

@@ src/awcg_mac.sv @@
// ============================================================================
// awcg_mac
// Two stages: four coefficient products, then the offsets on the row terms.
// ============================================================================
module awcg_mac
    import awcg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int PW = COEF_W + COORD_BITS + 1,
    localparam int QW = PW + 1
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  t_cfg                 i_cfg,
    output logic                 o_vld,
    output logic signed [QW-1:0] o_col_x,
    output logic signed [QW-1:0] o_col_y,
    output logic signed [QW-1:0] o_row_x,
    output logic signed [QW-1:0] o_row_y
);

    logic signed [COORD_BITS:0] w_xs;
    logic signed [COORD_BITS:0] w_ys;

    logic                 r_vld_p;
    logic signed [PW-1:0] r_pa, r_pb, r_pd, r_pe;
    logic                 r_vld_q;
    logic signed [QW-1:0] r_col_x, r_col_y, r_row_x, r_row_y;

    assign w_xs = $signed({1'b0, i_x});
    assign w_ys = $signed({1'b0, i_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= 1'b0;
            r_vld_q <= 1'b0;
        end else if (i_en) begin
            r_vld_p <= i_vld;
            r_vld_q <= r_vld_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= i_cfg.a * w_xs;
            r_pb <= i_cfg.b * w_ys;
            r_pd <= i_cfg.d * w_xs;
            r_pe <= i_cfg.e * w_ys;

            r_col_x <= {r_pa[PW-1], r_pa};
            r_col_y <= {r_pd[PW-1], r_pd};
            r_row_x <= {r_pb[PW-1], r_pb} + {{(QW-COEF_W){i_cfg.c[COEF_W-1]}}, i_cfg.c};
            r_row_y <= {r_pe[PW-1], r_pe} + {{(QW-COEF_W){i_cfg.f[COEF_W-1]}}, i_cfg.f};
        end
    end

    assign o_vld   = r_vld_q;
    assign o_col_x = r_col_x;
    assign o_col_y = r_col_y;
    assign o_row_x = r_row_x;
    assign o_row_y = r_row_y;

endmodule

@@ src/awcg_rnd.sv @@
// ============================================================================
// awcg_rnd
// Round each term to 1/2^AB_BITS units (ties to even, int32 saturation),
// then add column term, row term and the mode's rounding offset.
// ============================================================================
module awcg_rnd
    import awcg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int AB_BITS    = AB_MIN_BITS,
    localparam int QW  = COEF_W + COORD_BITS + 2,
    localparam int SW  = COEF_W + 2
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic                 i_mode,
    input  logic signed [QW-1:0] i_col_x,
    input  logic signed [QW-1:0] i_col_y,
    input  logic signed [QW-1:0] i_row_x,
    input  logic signed [QW-1:0] i_row_y,
    output logic                 o_vld,
    output logic signed [SW-1:0] o_sum_x,
    output logic signed [SW-1:0] o_sum_y
);

    localparam int RSH = COEF_FRAC_BITS - AB_BITS;
    localparam int QRW = QW - RSH + 1;
    localparam logic [RSH-1:0] HALF = RSH'(1 << (RSH - 1));
    localparam logic [COEF_W-1:0] INT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] INT_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [SW-1:0] RD_NEAR = SW'((1 << AB_BITS) / 2);
    localparam logic [SW-1:0] RD_BIL  = SW'((1 << AB_BITS) / (1 << FRAC_BITS) / 2);

    function automatic logic [COEF_W-1:0] round_sat(input logic [QW-1:0] v);
        logic [QW-RSH-1:0] q;
        logic [RSH-1:0]    r;
        logic              up;
        logic [QRW-1:0]    qr;
        q  = v[QW-1:RSH];
        r  = v[RSH-1:0];
        up = (r > HALF) || ((r == HALF) && q[0]);
        qr = {q[QW-RSH-1], q} + QRW'(up);
        if ((qr[QRW-1:COEF_W-1] == '0) || (qr[QRW-1:COEF_W-1] == '1)) begin
            return qr[COEF_W-1:0];
        end
        return qr[QRW-1] ? INT_MIN : INT_MAX;
    endfunction

    logic                     r_vld_r;
    logic signed [COEF_W-1:0] r_cx, r_cy, r_rx, r_ry;
    logic                     r_vld_s;
    logic signed [SW-1:0]     r_sum_x, r_sum_y;
    logic [SW-1:0]            w_rd;

    assign w_rd = (i_mode == MODE_BILINEAR) ? RD_BIL : RD_NEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_r <= 1'b0;
            r_vld_s <= 1'b0;
        end else if (i_en) begin
            r_vld_r <= i_vld;
            r_vld_s <= r_vld_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= $signed(round_sat(i_col_x));
            r_cy <= $signed(round_sat(i_col_y));
            r_rx <= $signed(round_sat(i_row_x));
            r_ry <= $signed(round_sat(i_row_y));

            // full width sum, no wrap
            r_sum_x <= {{2{r_cx[COEF_W-1]}}, r_cx} + {{2{r_rx[COEF_W-1]}}, r_rx} + w_rd;
            r_sum_y <= {{2{r_cy[COEF_W-1]}}, r_cy} + {{2{r_ry[COEF_W-1]}}, r_ry} + w_rd;
        end
    end

    assign o_vld   = r_vld_s;
    assign o_sum_x = r_sum_x;
    assign o_sum_y = r_sum_y;

endmodule

@@ src/awcg_out.sv @@
// ============================================================================
// awcg_out
// Output register: 16-bit saturated integer coordinates and fraction index.
// ============================================================================
module awcg_out
    import awcg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int AB_BITS   = AB_MIN_BITS,
    localparam int SW = COEF_W + 2
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic                 i_mode,
    input  logic signed [SW-1:0] i_sum_x,
    input  logic signed [SW-1:0] i_sum_y,
    output logic                 o_vld,
    output logic [OUT_W-1:0]     o_src_x,
    output logic [OUT_W-1:0]     o_src_y,
    output logic [FIDX_W-1:0]    o_frac_index
);

    localparam int TW = SW - AB_BITS;
    localparam logic [OUT_W-1:0] S16_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] S16_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    function automatic logic [OUT_W-1:0] sat16(input logic [TW-1:0] t);
        if ((t[TW-1:OUT_W-1] == '0) || (t[TW-1:OUT_W-1] == '1)) begin
            return t[OUT_W-1:0];
        end
        return t[TW-1] ? S16_MIN : S16_MAX;
    endfunction

    logic [2*FRAC_BITS-1:0] w_fidx;
    logic                   r_vld;
    logic [OUT_W-1:0]       r_src_x, r_src_y;
    logic [FIDX_W-1:0]      r_fidx;

    // fy above fx; truncated or zero-extended to the index width
    assign w_fidx = {i_sum_y[AB_BITS-1 -: FRAC_BITS], i_sum_x[AB_BITS-1 -: FRAC_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_src_x <= sat16(i_sum_x[SW-1:AB_BITS]);
            r_src_y <= sat16(i_sum_y[SW-1:AB_BITS]);
            r_fidx  <= (i_mode == MODE_BILINEAR) ? FIDX_W'(w_fidx) : '0;
        end
    end

    assign o_vld        = r_vld;
    assign o_src_x      = r_src_x;
    assign o_src_y      = r_src_y;
    assign o_frac_index = r_fidx;

endmodule

@@ src/affine_warp_coordinate_gen.sv @@
// ============================================================================
// affine_warp_coordinate_gen
// Maps destination pixel positions through a Q16.16 2x3 affine matrix.
// ============================================================================
// One transaction in, one transaction out. The datapath is a five-stage
// pipeline (products, offsets, rounding, sum, saturation/output register);
// a new coordinate can be accepted every cycle unless the output stalls.
// Backpressure on the master side stalls the whole pipeline in place;
// s_tready follows m_tready whenever the output register holds a result.
// Configuration writes are always accepted and must only be issued while
// the pipeline is empty.
module affine_warp_coordinate_gen
    import awcg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // dst_x, dst_y, zero pad
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // src_x, src_y, frac_index, zero pad
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COEF_W-1:0]      i_cfg_data
);

    localparam int AB_BITS = (AB_MIN_BITS > FRAC_BITS) ? AB_MIN_BITS : FRAC_BITS;
    localparam int QW      = COEF_W + COORD_BITS + 2;
    localparam int SW      = COEF_W + 2;

    t_cfg                 w_cfg;
    logic                 w_en;
    logic                 w_mac_vld;
    logic signed [QW-1:0] w_col_x, w_col_y, w_row_x, w_row_y;
    logic                 w_rnd_vld;
    logic signed [SW-1:0] w_sum_x, w_sum_y;
    logic                 w_out_vld;
    logic [OUT_W-1:0]     w_src_x, w_src_y;
    logic [FIDX_W-1:0]    w_fidx;

    assign w_en       = !w_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    awcg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    awcg_mac #(.COORD_BITS(COORD_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_x     (i_s_tdata[COORD_BITS-1:0]),
        .i_y     (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cfg   (w_cfg),
        .o_vld   (w_mac_vld),
        .o_col_x (w_col_x),
        .o_col_y (w_col_y),
        .o_row_x (w_row_x),
        .o_row_y (w_row_y)
    );

    awcg_rnd #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .AB_BITS    (AB_BITS)
    ) u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_mac_vld),
        .i_mode  (w_cfg.mode),
        .i_col_x (w_col_x),
        .i_col_y (w_col_y),
        .i_row_x (w_row_x),
        .i_row_y (w_row_y),
        .o_vld   (w_rnd_vld),
        .o_sum_x (w_sum_x),
        .o_sum_y (w_sum_y)
    );

    awcg_out #(
        .FRAC_BITS (FRAC_BITS),
        .AB_BITS   (AB_BITS)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_vld        (w_rnd_vld),
        .i_mode       (w_cfg.mode),
        .i_sum_x      (w_sum_x),
        .i_sum_y      (w_sum_y),
        .o_vld        (w_out_vld),
        .o_src_x      (w_src_x),
        .o_src_y      (w_src_y),
        .o_frac_index (w_fidx)
    );

    assign o_m_tvalid = w_out_vld;
    assign o_m_tdata  = {{(OUT_TDATA_W-2*OUT_W-FIDX_W){1'b0}}, w_fidx, w_src_y, w_src_x};

    // nearest mode never reports a fraction index
    a_nearest_no_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_cfg.mode == MODE_NEAREST)) |-> (w_fidx == '0))
        else $error("frac_index nonzero in nearest mode");

    // a stall freezes every stage's valid bit
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(w_mac_vld) && $stable(w_rnd_vld) && $stable(w_out_vld)))
        else $error("pipeline moved during stall");

    // a stalled result keeps its payload
    a_stall_holds_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("output payload changed during stall");

endmodule

@@ sim/tb_affine_warp_coordinate_gen.sv @@
// ============================================================================
// tb_affine_warp_coordinate_gen
// Self-checking testbench for the affine warp coordinate generator.
// ============================================================================
// Destination coordinates go in on the slave stream. Source coordinates come
// out on the master stream. Each accepted input is mapped here through a local
// copy of the matrix and mode registers, and the expected result is queued.
// Each output transaction is checked field by field against the head of that
// queue. Directed tests cover the reset matrix, bilinear fractions,
// tie-to-even rounding, saturation with wide sums, and writes that must be
// ignored. Random phases then load new matrices and stream coordinates under
// different source-gap and sink-stall profiles.
module tb_affine_warp_coordinate_gen;
    import awcg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AB_BITS      = (AB_MIN_BITS > FRAC_BITS_DEF) ? AB_MIN_BITS : FRAC_BITS_DEF;
    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int SCALE_SHIFT  = COEF_FRAC_BITS - AB_BITS;
    localparam longint ROUND_HALF       = longint'(1) <<< (SCALE_SHIFT - 1);
    localparam longint HALF_UNIT_OFFSET = longint'(1) <<< (AB_BITS - 1);
    localparam longint HALF_TAB_OFFSET  = (longint'(1) <<< AB_BITS) >>> (FRAC_BITS + 1);
    localparam longint INT32_HI   = 64'sd2147483647;
    localparam longint INT32_LO   = -64'sd2147483648;
    localparam int SETTLE_CYCLES  = 8;      // pipeline is five deep
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 200;
    localparam int NUM_PHASES     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // no register here

    localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

    typedef struct {
        logic [OUT_W-1:0]  src_x;
        logic [OUT_W-1:0]  src_y;
        logic [FIDX_W-1:0] frac_index;
    } t_warp_coord;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [2*COORD_BITS-1:0]      i_s_tdata;     // dst_x, dst_y
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [OUT_TDATA_W-1:0]       o_m_tdata;     // src_x, src_y, frac_index, zero pad
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [COEF_W-1:0]            i_cfg_data;

    t_cfg        warp_cfg;
    t_warp_coord pending_coords[$];
    int          mismatch_count;
    int          stalled_cycles;
    int          src_gap_pct;
    int          sink_stall_pct;

    affine_warp_coordinate_gen DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Coordinate mapping
    // ------------------------------------------------------------------------
    // Product at Q16.16 brought down to 1/2^AB_BITS units, nearest, ties to even
    function automatic longint round_product(input longint p);
        longint q;
        longint rem;
        q   = p >>> SCALE_SHIFT;
        rem = p - (q <<< SCALE_SHIFT);
        if (rem > ROUND_HALF || (rem == ROUND_HALF && q[0]))
            q = q + 1;
        if (q > INT32_HI)
            q = INT32_HI;
        if (q < INT32_LO)
            q = INT32_LO;
        return q;
    endfunction

    function automatic logic [OUT_W-1:0] clamp16(input longint v);
        if (v > 64'sd32767)
            return 16'h7FFF;
        if (v < -64'sd32768)
            return 16'h8000;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_warp_coord map_to_source(input logic [COORD_BITS-1:0] dx,
                                                  input logic [COORD_BITS-1:0] dy);
        longint      x, y, rd, sx, sy, tx, ty;
        t_warp_coord r;
        x  = dx;
        y  = dy;
        rd = (warp_cfg.mode == MODE_BILINEAR) ? HALF_TAB_OFFSET : HALF_UNIT_OFFSET;
        // terms saturate to int32 but their sums stay wide; the final coordinates saturate to 16 bits
        sx = round_product(longint'(warp_cfg.a) * x)
           + round_product(longint'(warp_cfg.b) * y + longint'(warp_cfg.c)) + rd;
        sy = round_product(longint'(warp_cfg.d) * x)
           + round_product(longint'(warp_cfg.e) * y + longint'(warp_cfg.f)) + rd;
        if (warp_cfg.mode == MODE_NEAREST) begin
            r.src_x      = clamp16(sx >>> AB_BITS);
            r.src_y      = clamp16(sy >>> AB_BITS);
            r.frac_index = '0;
        end else begin
            tx = sx >>> (AB_BITS - FRAC_BITS);
            ty = sy >>> (AB_BITS - FRAC_BITS);
            r.src_x      = clamp16(tx >>> FRAC_BITS);
            r.src_y      = clamp16(ty >>> FRAC_BITS);
            r.frac_index = FIDX_W'({ty[FRAC_BITS-1:0], tx[FRAC_BITS-1:0]});
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: register shadow, expected queue, output check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_warp_coord want;
        if (!i_rst_n) begin
            warp_cfg = '{a: COEF_ONE, b: COEF_ZERO, c: COEF_ZERO, d: COEF_ZERO,
                         e: COEF_ONE, f: COEF_ZERO, mode: MODE_NEAREST};
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_coords.size() == 0) begin
                    $error("output transaction with no coordinate pending: %h", o_m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_coords.pop_front();
                    if (o_m_tdata[15:0] !== want.src_x) begin
                        $error("src_x: expected %0d, got %0d",
                               $signed(want.src_x), $signed(o_m_tdata[15:0]));
                        mismatch_count++;
                    end
                    if (o_m_tdata[31:16] !== want.src_y) begin
                        $error("src_y: expected %0d, got %0d",
                               $signed(want.src_y), $signed(o_m_tdata[31:16]));
                        mismatch_count++;
                    end
                    if (o_m_tdata[41:32] !== want.frac_index) begin
                        $error("frac_index: expected %0d, got %0d",
                               want.frac_index, o_m_tdata[41:32]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[47:42] !== '0) begin
                        $error("pad: expected 0, got %0h", o_m_tdata[47:42]);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready)
                pending_coords.push_back(map_to_source(i_s_tdata[11:0], i_s_tdata[23:12]));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_COEF_A:      warp_cfg.a = i_cfg_data;
                    REG_COEF_B:      warp_cfg.b = i_cfg_data;
                    REG_COEF_C:      warp_cfg.c = i_cfg_data;
                    REG_COEF_D:      warp_cfg.d = i_cfg_data;
                    REG_COEF_E:      warp_cfg.e = i_cfg_data;
                    REG_COEF_F:      warp_cfg.f = i_cfg_data;
                    REG_INTERP_MODE: warp_cfg.mode = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // sink backpressure
    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers (called and returning at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_coord(input logic [COORD_BITS-1:0] dx,
                              input logic [COORD_BITS-1:0] dy);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {dy, dx};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_matrix(input t_cfg m);
        write_reg(REG_COEF_A, m.a);
        write_reg(REG_COEF_B, m.b);
        write_reg(REG_COEF_C, m.c);
        write_reg(REG_COEF_D, m.d);
        write_reg(REG_COEF_E, m.e);
        write_reg(REG_COEF_F, m.f);
        write_reg(REG_INTERP_MODE, COEF_W'(m.mode));
    endtask

    task automatic wait_pipeline_empty();
        i_s_tvalid = 1'b0;
        while (pending_coords.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // span is the half-width of the small-value range
    function automatic logic [COEF_W-1:0] pick_coef(input int unsigned span);
        case ($urandom_range(0, 9))
            0:       return COEF_MIN;
            1:       return COEF_MAX;
            2:       return $urandom();
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset matrix is identity in nearest mode
    task automatic test_reset_identity();
        send_coord(12'h000, 12'h000);
        send_coord(12'hFFF, 12'hFFF);
        send_coord(12'hAAA, 12'h555);
        send_coord(12'h555, 12'hAAA);
        wait_pipeline_empty();
    endtask

    task automatic test_bilinear_fraction();
        load_matrix('{a: 32'h0001_1111, b: 32'h0000_2222, c: 32'h0001_2345,
                      d: -32'sh0000_3333, e: 32'h0000_F0F0, f: -32'sh0000_4321,
                      mode: MODE_NEAREST});
        // upper data bits of the mode register are don't-care
        write_reg(REG_INTERP_MODE, 32'hFFFF_FFFF);
        send_coord(12'hFFF, 12'h000);
        send_coord(12'h000, 12'hFFF);
        send_coord(12'h001, 12'h001);
        send_coord(12'h801, 12'hBFF);
        wait_pipeline_empty();
    endtask

    // products landing exactly halfway between two scaled units, and one that does not
    task automatic test_rounding_ties();
        load_matrix('{a: 32'sd32, b: COEF_ZERO, c: 32'sd896,
                      d: -32'sd32, e: COEF_ZERO, f: 32'sd1024, mode: MODE_BILINEAR});
        send_coord(12'h001, 12'h000);
        send_coord(12'h003, 12'h000);
        send_coord(12'h002, 12'h000);
        wait_pipeline_empty();
    endtask

    task automatic test_saturation();
        // column and row terms pinned to the 32-bit limits at the far corner, sum kept wide
        load_matrix('{a: COEF_MIN, b: COEF_MIN, c: COEF_MIN, d: COEF_MIN,
                      e: COEF_MIN, f: COEF_MIN, mode: MODE_NEAREST});
        send_coord(12'hFFF, 12'hFFF);
        send_coord(12'h000, 12'h000);
        wait_pipeline_empty();
        load_matrix('{a: COEF_MAX, b: COEF_MAX, c: COEF_MAX, d: COEF_MAX,
                      e: COEF_MAX, f: COEF_MAX, mode: MODE_BILINEAR});
        send_coord(12'hFFF, 12'hFFF);
        send_coord(12'h000, 12'h000);
        wait_pipeline_empty();
        write_reg(REG_INTERP_MODE, 32'hFFFF_FFFE);
        send_coord(12'hFFF, 12'hFFF);
        wait_pipeline_empty();
        // write to an unmapped index must leave everything alone
        write_reg(REG_UNUSED, 32'h0000_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_coord(12'h001, 12'h001);
        wait_pipeline_empty();
    endtask

    task automatic test_random_stream();
        t_cfg m;
        logic [COORD_BITS-1:0] dx, dy;
        for (int p = 0; p < NUM_PHASES; p++) begin
            m.a    = pick_coef(32'h0004_0000);
            m.b    = pick_coef(32'h0004_0000);
            m.c    = pick_coef(32'h1000_0000);
            m.d    = pick_coef(32'h0004_0000);
            m.e    = pick_coef(32'h0004_0000);
            m.f    = pick_coef(32'h1000_0000);
            m.mode = 1'((p >> 2) & 1);
            load_matrix(m);
            write_reg(REG_INTERP_MODE, {$urandom_range(0, 1) ? 31'($urandom()) : 31'd0, m.mode});
            write_reg(REG_UNUSED, $urandom());
            case (p % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 53; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 53; end
                default: begin src_gap_pct = 9; sink_stall_pct = 9; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                dx = COORD_BITS'($urandom());
                dy = COORD_BITS'($urandom());
                if ($urandom_range(0, 15) == 0)
                    dx = $urandom_range(0, 1) ? '1 : '0;
                if ($urandom_range(0, 15) == 0)
                    dy = $urandom_range(0, 1) ? '1 : '0;
                send_coord(dx, dy);
            end
            wait_pipeline_empty();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_COEF_A;
        i_cfg_data     = '0;
        mismatch_count = 0;
        stalled_cycles = 0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_identity();
        test_bilinear_fraction();
        test_rounding_ties();
        test_saturation();
        test_random_stream();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
